[design/fll_pkg.sv]
// Shared types, codes and constants of the failure lockout limiter.
package fll_pkg;

  localparam int KEY_W = 6;
  localparam int KEY_SPACE = 1 << KEY_W;
  localparam int NUM_KEYS_DEFAULT = 64;
  localparam int TIME_W = 32;
  localparam int TICKS_W = 16;
  localparam int COUNT_W = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RESET = 16'd60;
  localparam logic [COUNT_W-1:0] ATTEMPT_LIMIT_RESET = 8'd5;
  localparam logic [TICKS_W-1:0] BLOCK_TICKS_RESET = 16'd300;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FAILURE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_TICKS  = 2'd0,
    REG_ATTEMPT_LIMIT = 2'd1,
    REG_BLOCK_TICKS   = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_index;
  } request_t;

  typedef struct packed {
    logic               limited;
    logic [TICKS_W-1:0] retry_after;
  } response_t;

  typedef struct packed {
    logic [COUNT_W-1:0] attempt_count;
    logic [TIME_W-1:0]  window_begin;
    logic [TIME_W-1:0]  block_end;
    logic               block_active;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

[design/fll_ctrl.sv]
// Controller state machine: capture a command beat, then execute it.
module fll_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output fll_pkg::ctl_t ctl
);

  fll_pkg::state_e state;
  fll_pkg::state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fll_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b0;
    case (state)
      fll_pkg::ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next = fll_pkg::ST_EXEC;
        end
      end
      fll_pkg::ST_EXEC: begin
        busy = 1'b1;
        ctl.execute = 1'b1;
        state_next = fll_pkg::ST_IDLE;
      end
      default: begin
        state_next = fll_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/fll_datapath.sv]
// Datapath: time counter, config registers, bucket table and update logic.
module fll_datapath #(
  parameter int NUM_KEYS = fll_pkg::NUM_KEYS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fll_pkg::ctl_t                     ctl,
  input  fll_pkg::request_t                 request,
  input  logic                              cfg_valid,
  input  logic [fll_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fll_pkg::TICKS_W-1:0]       cfg_data,
  output fll_pkg::response_t                response,
  output logic                              done
);

  localparam int DEPTH = (NUM_KEYS < fll_pkg::KEY_SPACE) ? NUM_KEYS : fll_pkg::KEY_SPACE;
  localparam int AW = $clog2(DEPTH);
  localparam logic [fll_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam logic [fll_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  fll_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [fll_pkg::TICKS_W-1:0] window_ticks;
  logic [fll_pkg::COUNT_W-1:0] attempt_limit;
  logic [fll_pkg::TICKS_W-1:0] block_ticks;
  logic [fll_pkg::TIME_W-1:0] current_time;

  fll_pkg::request_t req;
  fll_pkg::entry_t rd_entry;
  logic rd_valid;

  fll_pkg::entry_t cur;
  fll_pkg::entry_t upd;
  logic [AW-1:0] addr;
  logic in_range;
  logic blocked;
  logic expired;
  logic [fll_pkg::TIME_W-1:0] elapsed;
  logic [fll_pkg::TIME_W:0] end_sum;
  logic [fll_pkg::TIME_W-1:0] end_sat;
  logic [fll_pkg::TIME_W-1:0] remain;
  logic [fll_pkg::COUNT_W-1:0] count_base;
  logic [fll_pkg::COUNT_W-1:0] count_inc;
  fll_pkg::response_t response_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= fll_pkg::WINDOW_TICKS_RESET;
      attempt_limit <= fll_pkg::ATTEMPT_LIMIT_RESET;
      block_ticks <= fll_pkg::BLOCK_TICKS_RESET;
    end else if (cfg_valid) begin
      case (fll_pkg::reg_e'(cfg_index))
        fll_pkg::REG_WINDOW_TICKS:  window_ticks <= cfg_data;
        fll_pkg::REG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[fll_pkg::COUNT_W-1:0];
        fll_pkg::REG_BLOCK_TICKS:   block_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign addr = req.key_index[AW-1:0];
  assign in_range = 32'(req.key_index) < NUM_KEYS;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req <= request;
      rd_entry <= mem[request.key_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ctl.capture) begin
      rd_valid <= valid[request.key_index[AW-1:0]];
    end
  end

  always_comb begin
    cur = rd_valid ? rd_entry : '0;
    blocked = cur.block_active && (current_time < cur.block_end);
    elapsed = current_time - cur.window_begin;
    expired = elapsed > {16'd0, window_ticks};
    end_sum = {1'b0, current_time} + {17'd0, block_ticks};
    end_sat = end_sum[fll_pkg::TIME_W] ? TIME_MAX : end_sum[fll_pkg::TIME_W-1:0];
    remain = cur.block_end - current_time;
    count_base = expired ? '0 : cur.attempt_count;
    count_inc = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 1'b1;

    upd = cur;
    if (!blocked) begin
      upd.attempt_count = count_inc;
      if (expired || (count_base == '0)) begin
        upd.window_begin = current_time;
      end
      if (count_inc >= attempt_limit) begin
        upd.block_end = end_sat;
        upd.block_active = 1'b1;
        upd.attempt_count = '0;
        upd.window_begin = current_time;
      end
    end

    response_next = '0;
    if ((fll_pkg::cmd_e'(req.command) == fll_pkg::CMD_QUERY) && in_range && blocked) begin
      response_next.limited = 1'b1;
      response_next.retry_after = remain[fll_pkg::TICKS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute && in_range && (fll_pkg::cmd_e'(req.command) == fll_pkg::CMD_FAILURE)) begin
      mem[addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      current_time <= '0;
    end else if (ctl.execute) begin
      case (fll_pkg::cmd_e'(req.command))
        fll_pkg::CMD_TICK: begin
          if (current_time != TIME_MAX) begin
            current_time <= current_time + 1'b1;
          end
        end
        fll_pkg::CMD_FAILURE: begin
          if (in_range) begin
            valid[addr] <= 1'b1;
          end
        end
        fll_pkg::CMD_CLEAR: begin
          if (in_range) begin
            valid[addr] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      response <= response_next;
    end
  end

endmodule

[design/failure_lockout_limiter.sv]
// Top level of the failure lockout limiter.
// An accepted beat is registered at capture; its result is registered onto done at execute.
// New commands are taken only when idle: table read at capture, failure write-back at execute.
// The result beat overlaps the capture of the next command; the receiver cannot stall.
// Reset: clears time, config to defaults and all buckets at once through per-entry valid bits.
module failure_lockout_limiter #(
  parameter int NUM_KEYS = fll_pkg::NUM_KEYS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  fll_pkg::request_t                 request,
  output fll_pkg::response_t                response,
  output logic                              done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fll_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fll_pkg::TICKS_W-1:0]       cfg_data
);

  fll_pkg::ctl_t ctl;

  assign cfg_ready = 1'b1;

  fll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  fll_datapath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .response  (response),
    .done      (done)
  );

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat not executed");

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("missing result beat");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done) else $error("result beat without command");

  a_retry_only_limited: assert property (@(posedge clk) disable iff (rst)
    (done && !response.limited) |-> (response.retry_after == '0))
    else $error("retry time on unlimited result");

endmodule
